// ===== rtl/dbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dbp_pkg;

	localparam int TIME_BITS = 32;
	localparam int CFG_BITS  = 16;
	localparam int ADDR_BITS = 3;
	localparam int DATA_BITS = 32;

	localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET   = 16'd50;
	localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET = 16'd1000;

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_DEBOUNCE   = 1'b0,
		REG_LONG_PRESS = 1'b1
	} reg_idx_t;

	typedef logic [TIME_BITS-1:0] time_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] debounce_ms;
		logic [CFG_BITS-1:0] long_press_ms;
	} cfg_t;

	typedef struct packed {
		logic clear_long;
		logic clear_short;
		logic raw_level;
	} item_t;

	typedef struct packed {
		logic long_press;
		logic short_press;
		logic pressed;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/debounced_button_short_long_press.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir   Beat contents
// s_*       in    one millisecond tick: raw level and clear strobes
// m_*       out   one result per tick: pressed and latched flags
// apb       in    debounce_ms at 0x0, long_press_ms at 0x4
//
// One tick per cycle sustained while the output is not stalled; each beat
// passes the input register, then the result register, to the output.
// The tick counter, debounce and press state update as the input register
// hands its beat to the result register. Reset clears all state to the
// released level and both flags to zero. A stalled output holds its beat
// while one more input beat waits in the input register.

module debounced_button_short_long_press (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_tvalid,
	output logic                           s_tready,
	input  wire  [7:0]                     s_tdata, // raw_level, clear_short, clear_long, pad
	output logic                           m_tvalid,
	input  wire                            m_tready,
	output logic [7:0]                     m_tdata, // pressed, short_press, long_press, pad
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire  [dbp_pkg::ADDR_BITS-1:0]  paddr,
	input  wire  [dbp_pkg::DATA_BITS-1:0]  pwdata,
	output logic [dbp_pkg::DATA_BITS-1:0]  prdata,
	output logic                           pready
);
	import dbp_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    vld_s1;
	result_t res_now;
	result_t res_q;
	logic    out_vld_q;
	logic    advance;

	assign advance  = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (s_tready)
			vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			item_s1 <= item_t'(s_tdata[2:0]);
	end

	dbp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dbp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (res_now)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (!out_vld_q || m_tready)
			out_vld_q <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_now;
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {5'b0, res_q};

endmodule

`default_nettype wire

// ===== rtl/dbp_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dbp_cfg (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        psel,
	input  wire                        penable,
	input  wire                        pwrite,
	input  wire [dbp_pkg::ADDR_BITS-1:0] paddr,
	input  wire [dbp_pkg::DATA_BITS-1:0] pwdata,
	output logic [dbp_pkg::DATA_BITS-1:0] prdata,
	output logic                       pready,
	output dbp_pkg::cfg_t              cfg
);
	import dbp_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= DEBOUNCE_RESET;
			cfg_q.long_press_ms <= LONG_PRESS_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_DEBOUNCE:   cfg_q.debounce_ms   <= pwdata[CFG_BITS-1:0];
				REG_LONG_PRESS: cfg_q.long_press_ms <= pwdata[CFG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_DEBOUNCE:   prdata[CFG_BITS-1:0] = cfg_q.debounce_ms;
			REG_LONG_PRESS: prdata[CFG_BITS-1:0] = cfg_q.long_press_ms;
			default: ;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/dbp_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dbp_core (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    step,
	input  wire dbp_pkg::item_t    item,
	input  wire dbp_pkg::cfg_t     cfg,
	output dbp_pkg::result_t       result
);
	import dbp_pkg::*;

	time_t now_q;
	time_t last_change_q;
	time_t press_start_q;
	logic  prev_raw_q;
	logic  stable_q;
	logic  long_seen_q;
	logic  short_q;
	logic  long_q;

	time_t elapsed;
	time_t held;
	time_t debounce_t;
	time_t long_t;
	logic  raw_changed;
	logic  accept_level;
	logic  just_pressed;
	logic  just_released;
	logic  long_hit;
	logic  stable_nx;
	logic  long_seen_nx;
	logic  short_nx;
	logic  long_nx;
	time_t press_start_nx;

	assign debounce_t  = TIME_BITS'(cfg.debounce_ms);
	assign long_t      = TIME_BITS'(cfg.long_press_ms);
	assign raw_changed = item.raw_level != prev_raw_q;
	// a fresh raw edge restarts the debounce window at this tick
	assign elapsed     = raw_changed ? '0 : now_q - last_change_q;
	assign held        = now_q - press_start_q;

	assign accept_level  = (elapsed > debounce_t) && (item.raw_level != stable_q);
	assign just_pressed  = accept_level && !item.raw_level;
	assign just_released = accept_level && item.raw_level;

	always_comb begin
		stable_nx      = accept_level ? item.raw_level : stable_q;
		long_seen_nx   = long_seen_q;
		short_nx       = short_q;
		long_nx        = long_q;
		press_start_nx = press_start_q;
		if (just_pressed) begin
			press_start_nx = now_q;
			long_seen_nx   = 1'b0;
		end
		if (just_released) begin
			press_start_nx = '0;
			if (held >= long_t) begin
				if (!long_seen_q) begin
					long_nx      = 1'b1;
					long_seen_nx = 1'b1;
				end
			end else begin
				short_nx = 1'b1;
			end
		end
		// on the press tick the held time is zero
		long_hit = just_pressed ? (cfg.long_press_ms == '0) : (held >= long_t);
		if (!stable_nx && !long_seen_nx && long_hit) begin
			long_nx      = 1'b1;
			long_seen_nx = 1'b1;
		end
	end

	assign result.pressed     = !stable_nx;
	assign result.short_press = short_nx;
	assign result.long_press  = long_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q         <= '0;
			last_change_q <= '0;
			press_start_q <= '0;
			prev_raw_q    <= 1'b1;
			stable_q      <= 1'b1;
			long_seen_q   <= 1'b0;
			short_q       <= 1'b0;
			long_q        <= 1'b0;
		end else if (step) begin
			now_q         <= now_q + 1'b1;
			if (raw_changed)
				last_change_q <= now_q;
			press_start_q <= press_start_nx;
			prev_raw_q    <= item.raw_level;
			stable_q      <= stable_nx;
			long_seen_q   <= long_seen_nx;
			short_q       <= short_nx && !item.clear_short;
			long_q        <= long_nx && !item.clear_long;
		end
	end

endmodule

`default_nettype wire
